// ===== design/ssba_pkg.sv =====
// Shared types, constants and helper functions for the swap slot bitmap allocator.
`default_nettype none
package ssba_pkg;

    // Bitmap geometry (MAP_WORD_BITS must be a power of two)
    localparam int SLOT_COUNT    = 1024;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (SLOT_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_IDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int SLOT_NUM_W    = WORD_IDX_W + BIT_IDX_W;
    localparam int SLOT_W        = 10;
    localparam int LAST_BASE     = (MAP_WORDS - 1) * MAP_WORD_BITS;

    typedef logic [MAP_WORD_BITS-1:0] t_word;
    typedef logic [WORD_IDX_W-1:0]    t_word_idx;
    typedef logic [BIT_IDX_W-1:0]     t_bit_idx;
    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic [SLOT_NUM_W-1:0]    t_slot_num;

    // Request modes
    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_BAD       = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        t_mode mode;
        t_slot slot;
    } t_cmd;

    typedef struct packed {
        t_slot   granted_slot;
        t_status status;
    } t_result;

    // Bitmap memory access from the controller
    typedef struct packed {
        logic      rd_en;
        t_word_idx rd_addr;
        logic      wr_en;
        t_word_idx wr_addr;
        t_word     wr_data;
    } t_ram_req;

    // Slots that exist in the last word (bits past SLOT_COUNT count as used)
    function automatic t_word last_word_mask();
        t_word m;
        m = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            m[i] = ((LAST_BASE + i) < SLOT_COUNT);
        end
        return m;
    endfunction

    localparam t_word LAST_MASK = last_word_mask();

    // Binary index of a one-hot word
    function automatic t_bit_idx onehot_to_idx(input t_word onehot);
        t_bit_idx idx;
        idx = '0;
        for (int unsigned i = 0; i < MAP_WORD_BITS; i++) begin
            for (int j = 0; j < BIT_IDX_W; j++) begin
                if (i[j]) begin
                    idx[j] = idx[j] | onehot[i];
                end
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== design/ssba_map_ram.sv =====
// Bitmap word memory with per-word valid bits so unwritten words read as zero.
`default_nettype none
module ssba_map_ram (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssba_pkg::t_ram_req i_req,
    output ssba_pkg::t_word        o_rd_data
);

    ssba_pkg::t_word                  r_mem [ssba_pkg::MAP_WORDS];
    logic [ssba_pkg::MAP_WORDS-1:0]   r_valid;
    ssba_pkg::t_word                  r_rd_data;
    logic                             r_rd_valid;

    // Storage write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Valid bits: reset marks every word as all-free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== design/ssba_ctrl.sv =====
// Allocator sequencer: word scan, read-modify-write and result register.
`default_nettype none
module ssba_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire ssba_pkg::t_cmd     i_cmd,
    output logic                    o_busy,
    output logic                    o_strobe,
    output ssba_pkg::t_result       o_result,
    output ssba_pkg::t_ram_req      o_ram_req,
    input  wire ssba_pkg::t_word    i_rd_data
);

    ssba_pkg::t_state    r_state, n_state;
    ssba_pkg::t_word_idx r_chk, n_chk;
    ssba_pkg::t_bit_idx  r_bit, n_bit;
    logic                r_strobe, n_strobe;
    ssba_pkg::t_result   r_result, n_result;

    logic                accept;
    logic                bad_slot;
    ssba_pkg::t_slot_num free_num;
    logic                last_word;
    ssba_pkg::t_word     free_bits;
    ssba_pkg::t_word     lowest;
    logic                found;
    ssba_pkg::t_bit_idx  found_idx;

    assign accept   = i_start && (r_state == ssba_pkg::S_IDLE);
    assign bad_slot = (int'(i_cmd.slot) >= ssba_pkg::SLOT_COUNT);
    assign free_num = ssba_pkg::SLOT_NUM_W'(i_cmd.slot);

    // First-fit search on the word that just came back from memory
    assign last_word = (r_chk == ssba_pkg::WORD_IDX_W'(ssba_pkg::MAP_WORDS - 1));
    assign free_bits = ~i_rd_data & (last_word ? ssba_pkg::LAST_MASK : '1);
    assign lowest    = free_bits & (~free_bits + ssba_pkg::MAP_WORD_BITS'(1));
    assign found     = |free_bits;
    assign found_idx = ssba_pkg::onehot_to_idx(lowest);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssba_pkg::S_IDLE: begin
                if (accept && i_cmd.mode == ssba_pkg::MODE_ALLOC) begin
                    n_state = ssba_pkg::S_SCAN;
                end else if (accept && !bad_slot) begin
                    n_state = ssba_pkg::S_FREE;
                end
            end
            ssba_pkg::S_SCAN: begin
                if (found || last_word) begin
                    n_state = ssba_pkg::S_IDLE;
                end
            end
            ssba_pkg::S_FREE: n_state = ssba_pkg::S_IDLE;
            default:          n_state = ssba_pkg::S_IDLE;
        endcase
    end

    // Outputs, memory requests and datapath updates
    always_comb begin
        o_busy    = (r_state != ssba_pkg::S_IDLE);
        o_ram_req = '0;
        n_chk     = r_chk;
        n_bit     = r_bit;
        n_strobe  = 1'b0;
        n_result  = r_result;
        case (r_state)
            ssba_pkg::S_IDLE: begin
                if (accept && i_cmd.mode == ssba_pkg::MODE_ALLOC) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = '0;
                    n_chk             = '0;
                end else if (accept && bad_slot) begin
                    n_strobe              = 1'b1;
                    n_result.granted_slot = '0;
                    n_result.status       = ssba_pkg::ST_BAD;
                end else if (accept) begin
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = free_num[ssba_pkg::SLOT_NUM_W-1:ssba_pkg::BIT_IDX_W];
                    n_chk             = free_num[ssba_pkg::SLOT_NUM_W-1:ssba_pkg::BIT_IDX_W];
                    n_bit             = free_num[ssba_pkg::BIT_IDX_W-1:0];
                end
            end
            ssba_pkg::S_SCAN: begin
                if (found) begin
                    // mark the slot and hand it out
                    o_ram_req.wr_en       = 1'b1;
                    o_ram_req.wr_addr     = r_chk;
                    o_ram_req.wr_data     = i_rd_data | lowest;
                    n_strobe              = 1'b1;
                    n_result.granted_slot = ssba_pkg::SLOT_W'({r_chk, found_idx});
                    n_result.status       = ssba_pkg::ST_ALLOCATED;
                end else if (last_word) begin
                    n_strobe              = 1'b1;
                    n_result.granted_slot = '0;
                    n_result.status       = ssba_pkg::ST_FULL;
                end else begin
                    // keep one read in flight ahead of the check
                    o_ram_req.rd_en   = 1'b1;
                    o_ram_req.rd_addr = r_chk + ssba_pkg::WORD_IDX_W'(1);
                    n_chk             = r_chk + ssba_pkg::WORD_IDX_W'(1);
                end
            end
            ssba_pkg::S_FREE: begin
                o_ram_req.wr_en       = 1'b1;
                o_ram_req.wr_addr     = r_chk;
                o_ram_req.wr_data     = i_rd_data & ~(ssba_pkg::MAP_WORD_BITS'(1) << r_bit);
                n_strobe              = 1'b1;
                n_result.granted_slot = '0;
                n_result.status       = ssba_pkg::ST_FREED;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssba_pkg::S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_bit    <= n_bit;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== design/swap_slot_bitmap_allocator_top.sv =====
// Top level of the swap slot bitmap allocator: sequencer plus bitmap memory.
// Allocate: the result strobe comes once the scan reaches the word that holds the first free slot
//   (one bitmap word read per cycle); full reports after the last word is checked.
// Free: strobe after a read, then a write back; bad slot: strobe in the cycle after acceptance.
// A new command is taken in the cycle its predecessor's result is on the ports; the
//   receiver cannot stall. Synchronous reset marks every slot free at once (valid bits).
`default_nettype none
module swap_slot_bitmap_allocator_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ssba_pkg::t_cmd i_cmd,
    output logic                o_strobe,
    output ssba_pkg::t_result   o_result
);

    ssba_pkg::t_ram_req ram_req;
    ssba_pkg::t_word    rd_data;

    ssba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .o_ram_req (ram_req),
        .i_rd_data (rd_data)
    );

    ssba_map_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

// ===== design/ssba_checker.sv =====
// Port-level assertion checker for the allocator and its bind to the top level.
`default_nettype none
module ssba_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire ssba_pkg::t_cmd    i_cmd,
    input wire logic              o_strobe,
    input wire ssba_pkg::t_result o_result
);

    logic accept;
    assign accept = start && !busy;

    // Out-of-range free answers in the very next cycle
    a_bad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.mode == ssba_pkg::MODE_FREE
            && int'(i_cmd.slot) >= ssba_pkg::SLOT_COUNT
        |=> o_strobe && o_result.status == ssba_pkg::ST_BAD)
        else $error("bad-slot free did not report next cycle");

    // Valid free completes after its read-modify-write
    a_free_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.mode == ssba_pkg::MODE_FREE
            && int'(i_cmd.slot) < ssba_pkg::SLOT_COUNT
        |=> busy && !o_strobe ##1 o_strobe && o_result.status == ssba_pkg::ST_FREED)
        else $error("free did not complete in two cycles");

    // Allocate needs at least one memory read before answering
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.mode == ssba_pkg::MODE_ALLOC |=> busy && !o_strobe)
        else $error("allocate answered without a bitmap read");

    // Only an allocation carries a slot number
    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ssba_pkg::ST_ALLOCATED
        |-> o_result.granted_slot == '0)
        else $error("non-allocate result with nonzero slot");

endmodule

bind swap_slot_bitmap_allocator_top ssba_checker u_ssba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the swap slot bitmap allocator: directed and random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int GAP_PCT     = 12;     // sender idle chance per cycle

    // One queued request plus its pacing hints
    typedef struct {
        ssba_pkg::t_cmd cmd;
        bit   steady;       // no random gap before this one
        bit   drain_first;  // hold off until all results are back
    } t_stim;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    ssba_pkg::t_cmd    i_cmd;
    logic              o_strobe;
    ssba_pkg::t_result o_result;

    t_stim             stim_q[$];
    ssba_pkg::t_result predicted_results[$];
    logic [ssba_pkg::SLOT_COUNT-1:0] slot_taken;   // shadow of the used bitmap

    int  n_total;
    int  n_accepted;
    int  mismatches;
    int  quiet_cycles;
    logic cmd_taken;

    swap_slot_bitmap_allocator_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Report one mismatch and count it
    task automatic note_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one request to the shadow bitmap and return what the block should answer
    function automatic ssba_pkg::t_result apply_request(input ssba_pkg::t_cmd cmd);
        ssba_pkg::t_result r;
        logic              found;
        r.granted_slot = '0;
        r.status       = ssba_pkg::ST_FULL;
        found          = 1'b0;
        if (cmd.mode == ssba_pkg::MODE_ALLOC) begin
            // lowest free slot wins
            for (int s = 0; s < ssba_pkg::SLOT_COUNT; s++) begin
                if (!found && !slot_taken[s]) begin
                    found          = 1'b1;
                    slot_taken[s]  = 1'b1;
                    r.granted_slot = ssba_pkg::t_slot'(s);
                    r.status       = ssba_pkg::ST_ALLOCATED;
                end
            end
        end else if (int'(cmd.slot) >= ssba_pkg::SLOT_COUNT) begin
            r.status = ssba_pkg::ST_BAD;
        end else begin
            // freeing an already free slot is harmless
            slot_taken[cmd.slot] = 1'b0;
            r.status             = ssba_pkg::ST_FREED;
        end
        return r;
    endfunction

    task automatic queue_cmd(input ssba_pkg::t_mode m, input ssba_pkg::t_slot s,
                             input bit steady, input bit drain_first);
        t_stim it;
        it.cmd.mode    = m;
        it.cmd.slot    = s;
        it.steady      = steady;
        it.drain_first = drain_first;
        stim_q.push_back(it);
    endtask

    function automatic ssba_pkg::t_mode pick_mode(input int alloc_pct);
        return ($urandom_range(0, 99) < alloc_pct) ? ssba_pkg::MODE_ALLOC
                                                   : ssba_pkg::MODE_FREE;
    endfunction

    // Driver: new transaction at the falling edge, start held until taken
    always @(negedge i_clk) begin : drive
        t_stim it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_taken) begin
            // still waiting for the block to take it
        end else if (stim_q.size() == 0) begin
            start <= 1'b0;
        end else if (stim_q[0].drain_first && predicted_results.size() != 0) begin
            start <= 1'b0;
        end else if (!stim_q[0].steady && $urandom_range(0, 99) < GAP_PCT) begin
            start <= 1'b0;
        end else begin
            it    = stim_q.pop_front();
            i_cmd <= it.cmd;
            start <= 1'b1;
        end
    end

    // Monitor: check results, then record accepted requests, then watchdog
    always @(posedge i_clk) begin : observe
        ssba_pkg::t_result want;
        logic              took;
        logic              got_res;
        took    = i_rst_n && start && (busy === 1'b0);
        got_res = i_rst_n && (o_strobe === 1'b1);
        if (got_res) begin
            if (predicted_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result slot=%0d status=%0d",
                                        o_result.granted_slot, o_result.status));
            end else begin
                want = predicted_results.pop_front();
                if (o_result.granted_slot !== want.granted_slot)
                    note_mismatch($sformatf("granted_slot got %0d want %0d",
                                            o_result.granted_slot, want.granted_slot));
                if (o_result.status !== want.status)
                    note_mismatch($sformatf("status got %0d want %0d",
                                            o_result.status, want.status));
            end
        end
        if (took) begin
            predicted_results.push_back(apply_request(i_cmd));
            n_accepted++;
        end
        cmd_taken <= took;
        if (took || got_res) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus build, reset and end of run
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        cmd_taken    = 1'b0;
        slot_taken   = '0;
        n_accepted   = 0;
        mismatches   = 0;
        quiet_cycles = 0;

        // Directed: field extremes, ignored slot on allocate, double free
        queue_cmd(ssba_pkg::MODE_ALLOC, '0, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, '1, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, 10'h155, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'd1, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'd1, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, 10'h2AA, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, '1, 1'b1, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, '0, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, '0, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'd2, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'h2AA, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'h155, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, 10'h3FF, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, '0, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'd0, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_FREE, 10'd2, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, 10'h0F0, 1'b0, 1'b0);
        queue_cmd(ssba_pkg::MODE_ALLOC, 10'h30F, 1'b0, 1'b0);

        // Random mix, frees leaning to low slots so some hit used ones
        for (int i = 0; i < 30; i++) begin
            if (pick_mode(75) == ssba_pkg::MODE_ALLOC)
                queue_cmd(ssba_pkg::MODE_ALLOC, ssba_pkg::t_slot'($urandom()), 1'b0, 1'b0);
            else if ($urandom_range(0, 1) == 0)
                queue_cmd(ssba_pkg::MODE_FREE, ssba_pkg::t_slot'($urandom_range(0, 127)),
                          1'b0, 1'b0);
            else
                queue_cmd(ssba_pkg::MODE_FREE, ssba_pkg::t_slot'($urandom()), 1'b0, 1'b0);
        end

        // Fill until full; first stretch back to back, sender drains first
        for (int i = 0; i < 1015; i++) begin
            queue_cmd(ssba_pkg::MODE_ALLOC, ssba_pkg::t_slot'($urandom()), i < 300, i == 0);
        end

        // Near full: free random slots, refill them, sometimes stay full
        for (int i = 0; i < 30; i++) begin
            queue_cmd(pick_mode(50), ssba_pkg::t_slot'($urandom()), 1'b0, i == 0);
        end

        n_total = stim_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || predicted_results.size() != 0) @(posedge i_clk);
        repeat (ssba_pkg::MAP_WORDS + 4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
